FILE: hdl/sds_pkg.sv
// Shared types and constants for the substring delete stream block.
// No dependencies; compile before every other file of the block.
package sds_pkg;

  // Field widths fixed by the stream and register formats
  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned PATTERN_W       = 64;
  localparam int unsigned LEN_W           = 4;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned MAX_PATTERN_DEF = 8;

  // Entries of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES  = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1
  } cfg_idx_e;

  // Control part of one queued command
  typedef struct packed {
    logic emit;  // one byte leaves the head of the window
    logic last;  // string ends: flush the held bytes and mark the end
  } sds_ctrl_t;

  localparam int unsigned CTRL_W = $bits(sds_ctrl_t);

endpackage

FILE: hdl/sds_if.sv
// Stream channel interfaces (valid/ready) for input bytes and result bytes.
// Depends on sds_pkg for the field widths.
interface sds_in_if import sds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface sds_out_if import sds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              char_present;
  logic              out_last;

  modport source (output valid, output out_char, output char_present, output out_last,
                  input ready);
  modport sink   (input valid, input out_char, input char_present, input out_last,
                  output ready);
endinterface

FILE: hdl/sds_front.sv
// Front end: configuration registers, match window and per-byte classification.
// Depends on sds_pkg; feeds commands into sds_queue.
module sds_front import sds_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int unsigned FILL_W      = $clog2(MAX_PATTERN + 1),
  parameter int unsigned CMD_W       = CTRL_W + CHAR_W + FILL_W + CHAR_W * MAX_PATTERN
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PATTERN_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CHAR_W-1:0]    in_char_i,
  input  logic                 in_last_i,
  output logic                 push_o,
  output logic [CMD_W-1:0]     cmd_o,
  input  logic                 full_i
);

  logic [PATTERN_W-1:0] pattern_q;
  logic [LEN_W-1:0]     plen_q;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [CHAR_W-1:0]    window_q [MAX_PATTERN];
  logic [CHAR_W-1:0]    window_d [MAX_PATTERN];
  logic [CHAR_W-1:0]    app      [MAX_PATTERN];
  logic [CHAR_W-1:0]    shifted  [MAX_PATTERN];
  logic [LEN_W-1:0]     len_raw;
  logic [FILL_W-1:0]    len_eff;
  logic [FILL_W-1:0]    slot;
  logic                 acc, full_win, match, cfg_hit;
  sds_ctrl_t            ctrl;
  logic [CHAR_W*MAX_PATTERN-1:0] flush_data;

  assign acc        = in_valid_i && in_ready_o;
  assign in_ready_o = !full_i;
  assign cfg_hit    = cfg_we_i && (cfg_idx_i == CFG_PATTERN_BYTES ||
                                   cfg_idx_i == CFG_PATTERN_LENGTH);

  // Clamp the programmed length into 1..MAX_PATTERN
  always_comb begin
    if (plen_q == '0) begin
      len_raw = LEN_W'(1);
    end else if (plen_q > LEN_W'(MAX_PATTERN)) begin
      len_raw = LEN_W'(MAX_PATTERN);
    end else begin
      len_raw = plen_q;
    end
  end
  assign len_eff = FILL_W'(len_raw);

  // Slot for the new byte; a window left full is restarted
  assign slot     = (fill_q >= len_eff) ? '0 : fill_q;
  assign full_win = (slot + FILL_W'(1)) == len_eff;

  // Append, compare all pattern bytes in parallel, and form the shifted window
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      app[i] = (FILL_W'(i) == slot) ? in_char_i : window_q[i];
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (FILL_W'(i) < len_eff && app[i] != pattern_q[CHAR_W*i +: CHAR_W]) begin
        match = 1'b0;
      end
      shifted[i] = app[(i + 1) % MAX_PATTERN];
    end
  end

  // Decide emission, next window and fill
  always_comb begin
    ctrl.emit = 1'b0;
    ctrl.last = in_last_i;
    window_d  = app;
    fill_d    = fill_q;
    if (acc) begin
      fill_d = slot + FILL_W'(1);
      if (full_win && match) begin
        fill_d = '0;
      end else if (full_win) begin
        ctrl.emit = 1'b1;
        window_d  = shifted;
        fill_d    = len_eff - FILL_W'(1);
      end
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      flush_data[CHAR_W*i +: CHAR_W] = window_d[i];
    end
  end

  // Queue a command whenever a byte leaves or the string ends
  assign push_o = acc && (ctrl.emit || ctrl.last);
  assign cmd_o  = {ctrl, app[0], (ctrl.last ? fill_d : FILL_W'(0)), flush_data};

  // Configuration registers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      plen_q    <= LEN_W'(1);
      fill_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_PATTERN_BYTES) begin
        pattern_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_PATTERN_LENGTH) begin
        plen_q <= cfg_data_i[LEN_W-1:0];
      end
      if (cfg_hit || (acc && in_last_i)) begin
        fill_q <= '0;
      end else begin
        fill_q <= fill_d;
      end
    end
  end

  // Window bytes hold no reset value
  always_ff @(posedge clk_i) begin
    if (acc) begin
      window_q <= window_d;
    end
  end

`ifndef SYNTH
  a_fill_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < len_eff)
    else $error("window fill reached the pattern length");
  a_cfg_clears_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> fill_q == '0)
    else $error("register write did not discard the window");
`endif

endmodule

FILE: hdl/sds_queue.sv
// Two-entry command queue between the classifying front and the output back end.
// Depends on sds_pkg for the queue depth.
module sds_queue import sds_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_q];

  // Advance pointers; depth is a power of two so they wrap on their own
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i |-> !full_o) and (pop_i |-> !empty_o))
    else $error("command queue overflow or underflow");
`endif

endmodule

FILE: hdl/sds_back.sv
// Back end: expands queued commands into result transfers through an output register.
// Depends on sds_pkg; reads commands from sds_queue.
module sds_back import sds_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int unsigned FILL_W      = $clog2(MAX_PATTERN + 1),
  parameter int unsigned CMD_W       = CTRL_W + CHAR_W + FILL_W + CHAR_W * MAX_PATTERN
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  logic [CMD_W-1:0]  cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAR_W-1:0] out_char_o,
  output logic              char_present_o,
  output logic              out_last_o
);

  localparam int unsigned SEQ_W = CHAR_W * MAX_PATTERN;

  sds_ctrl_t         c_ctrl;
  logic [CHAR_W-1:0] c_char;
  logic [FILL_W-1:0] c_cnt;
  logic [SEQ_W-1:0]  c_data;

  logic              busy_q, busy_d;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic [FILL_W-1:0] n_q, n_d;
  logic              last_q, last_d;
  logic              ov_q, ov_d;
  logic [CHAR_W-1:0] oc_q, oc_d;
  logic              op_q, op_d, ol_q, ol_d;
  logic              adv, done, load;

  assign {c_ctrl, c_char, c_cnt, c_data} = cmd_i;

  assign adv   = busy_q && (!ov_q || out_ready_i);
  assign done  = adv && (n_q <= FILL_W'(1));
  assign load  = !empty_i && (!busy_q || done);
  assign pop_o = load;

  // Step through the bytes of the current command, one transfer a cycle unless the output stalls
  always_comb begin
    busy_d = busy_q;
    seq_d  = seq_q;
    n_d    = n_q;
    last_d = last_q;
    ov_d   = ov_q && !out_ready_i;
    oc_d   = oc_q;
    op_d   = op_q;
    ol_d   = ol_q;
    if (adv) begin
      ov_d  = 1'b1;
      op_d  = n_q != '0;
      oc_d  = (n_q != '0) ? seq_q[CHAR_W-1:0] : '0;
      ol_d  = last_q && (n_q <= FILL_W'(1));
      seq_d = seq_q >> CHAR_W;
      n_d   = (n_q != '0) ? n_q - FILL_W'(1) : '0;
    end
    if (done) begin
      busy_d = 1'b0;
    end
    // Load the next command, with the emitted byte ahead of the flushed ones
    if (load) begin
      busy_d = 1'b1;
      last_d = c_ctrl.last;
      seq_d  = c_ctrl.emit ? SEQ_W'({c_data, c_char}) : c_data;
      n_d    = c_cnt + FILL_W'(c_ctrl.emit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q  <= seq_d;
    n_q    <= n_d;
    last_q <= last_d;
    oc_q   <= oc_d;
    op_q   <= op_d;
    ol_q   <= ol_d;
  end

  assign out_valid_o    = ov_q;
  assign out_char_o     = oc_q;
  assign char_present_o = op_q;
  assign out_last_o     = ol_q;

`ifndef SYNTH
  a_bare_marker_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !op_q |-> ol_q)
    else $error("bare end marker without last flag");
  a_empty_cmd_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && n_q == '0 |-> last_q)
    else $error("empty command that does not end a string");
`endif

endmodule

FILE: hdl/substring_delete_stream.sv
// Top level of the substring delete stream block.
// Depends on sds_pkg, sds_if, sds_front, sds_queue and sds_back.

// Deletes every leftmost, non-overlapping occurrence of a pattern of 1 to
// MAX_PATTERN bytes from a byte stream whose strings end on a byte flagged
// in_last. The input takes one byte per cycle while the queue has room; the
// front compares the whole window with the pattern in parallel in the cycle a
// byte arrives. The back end gives one result transfer per cycle while the
// result side is ready: a byte that leaves the window, then at string end every
// held byte (up to MAX_PATTERN results for that final input), or a bare marker
// with char_present low when nothing is left. A two-entry command queue lets
// the input keep flowing while the back end flushes; the input stalls when
// that flush outlasts the queue, or when the result side holds off long enough
// to fill it. Writing either register discards held bytes.
module substring_delete_stream import sds_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PATTERN_W-1:0] cfg_data_i,
  sds_in_if.sink               in_i,
  sds_out_if.source            out_o
);

  localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned CMD_W  = CTRL_W + CHAR_W + FILL_W + CHAR_W * MAX_PATTERN;

  logic             push, full, pop, empty;
  logic [CMD_W-1:0] cmd_w, cmd_r;

  // Classify input bytes
  sds_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .FILL_W      (FILL_W),
    .CMD_W       (CMD_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_char_i  (in_i.in_char),
    .in_last_i  (in_i.in_last),
    .push_o     (push),
    .cmd_o      (cmd_w),
    .full_i     (full)
  );

  // Decouple front and back
  sds_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_w),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (cmd_r),
    .empty_o (empty)
  );

  // Expand commands into result transfers
  sds_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .FILL_W      (FILL_W),
    .CMD_W       (CMD_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .cmd_i          (cmd_r),
    .pop_o          (pop),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_char_o     (out_o.out_char),
    .char_present_o (out_o.char_present),
    .out_last_o     (out_o.out_last)
  );

endmodule
